// ===== rtl/wpsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wpsp_pkg
// Shared types and constants for the world point screen projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package wpsp_pkg;

  localparam int CoordFracBits = 8;   // fraction bits of world coordinates
  localparam int RelW   = 24;         // saturated relative vector
  localparam int EntryW = 16;         // matrix entry
  localparam int ClipW  = 41;         // clip coordinate
  localparam int AxisW  = 42;         // cx + cw and cw - cy
  localparam int QuotW  = 20;         // screen coordinate
  localparam int RemW   = 60;         // dividend and running remainder
  localparam int DenW   = 42;         // doubled clip w
  localparam int CmpW   = 62;         // divisor shifted by the quotient width
  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;

  typedef enum logic [2:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_ROW3   = 3'd3,
    REG_ORG_X  = 3'd4,
    REG_ORG_Y  = 3'd5,
    REG_ORG_Z  = 3'd6,
    REG_VPORT  = 3'd7
  } reg_idx_e;

  // One classified point on its way from the front to the back.
  typedef struct packed {
    logic                    vis;
    logic signed [AxisW-1:0] ax;
    logic signed [AxisW-1:0] ay;
    logic signed [ClipW-1:0] cw;
  } q_item_t;

  // Status of the front pipeline, seen by the top level.
  typedef struct packed {
    logic out_valid;
    logic advance;
  } front_stat_t;

endpackage

`default_nettype wire

// ===== rtl/wpsp_front.sv =====
// ----------------------------------------------------------------------------
// wpsp_front
// Origin subtraction, matrix transform and visibility classification.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsp_front
  import wpsp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic [95:0]  in_data_i,
  input  wire logic [63:0]  row0_i,
  input  wire logic [63:0]  row1_i,
  input  wire logic [63:0]  row3_i,
  input  wire logic [31:0]  org_x_i,
  input  wire logic [31:0]  org_y_i,
  input  wire logic [31:0]  org_z_i,
  input  wire logic         q_ready_i,
  output q_item_t           q_item_o,
  output front_stat_t       stat_o
);

  localparam logic signed [RelW-1:0] CoordOne = RelW'(1 << CoordFracBits);

  logic [2:0] vld_q;
  logic       item_vld_q;
  logic       adv;

  logic signed [RelW-1:0]  rel_q [3];
  logic signed [RelW-1:0]  rel_d [3];
  logic signed [39:0]      prod_q [3][4];
  logic signed [ClipW-1:0] cx_q, cy_q, cw_q;
  q_item_t                 item_q;

  assign adv = !item_vld_q || q_ready_i;

  always_comb begin
    logic signed [32:0] diff;
    logic signed [31:0] pt;
    logic signed [31:0] org;
    for (int i = 0; i < 3; i++) begin
      pt  = in_data_i[32*i +: 32];
      org = (i == 0) ? org_x_i : ((i == 1) ? org_y_i : org_z_i);
      diff = 33'(pt) - 33'(org);
      if (diff > 33'sd8388607) begin
        rel_d[i] = 24'sh7FFFFF;
      end else if (diff < -33'sd8388608) begin
        rel_d[i] = 24'sh800000;
      end else begin
        rel_d[i] = diff[RelW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [63:0]             row;
    logic signed [RelW-1:0]  v;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rel_q[i] <= rel_d[i];
      end
      for (int r = 0; r < 3; r++) begin
        row = (r == 0) ? row0_i : ((r == 1) ? row1_i : row3_i);
        for (int c = 0; c < 4; c++) begin
          v = (c == 3) ? CoordOne : rel_q[c];
          prod_q[r][c] <= $signed(row[16*c +: EntryW]) * v;
        end
      end
      cx_q <= ClipW'(prod_q[0][0]) + ClipW'(prod_q[0][1])
            + ClipW'(prod_q[0][2]) + ClipW'(prod_q[0][3]);
      cy_q <= ClipW'(prod_q[1][0]) + ClipW'(prod_q[1][1])
            + ClipW'(prod_q[1][2]) + ClipW'(prod_q[1][3]);
      cw_q <= ClipW'(prod_q[2][0]) + ClipW'(prod_q[2][1])
            + ClipW'(prod_q[2][2]) + ClipW'(prod_q[2][3]);
    end
  end

  // Last stage: the item that waits for the queue.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q.vis <= (cw_q > 0);
      item_q.ax  <= AxisW'(cx_q) + AxisW'(cw_q);
      item_q.ay  <= AxisW'(cw_q) - AxisW'(cy_q);
      item_q.cw  <= cw_q;
    end
  end

  // The clip stage feeds the item register; its valid bit follows it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (adv) begin
      item_vld_q <= vld_q[2];
    end
  end

  assign q_item_o         = item_q;
  assign stat_o.out_valid = item_vld_q;
  assign stat_o.advance   = adv;

endmodule

`default_nettype wire

// ===== rtl/wpsp_fifo.sv =====
// ----------------------------------------------------------------------------
// wpsp_fifo
// Short queue between the classification front and the divider back.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsp_fifo
  import wpsp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  q_item_t   push_item_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output q_item_t   pop_item_o
);

  q_item_t            mem_q [FifoDepth];
  logic [FifoAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]    cnt_q;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wpsp_back.sv =====
// ----------------------------------------------------------------------------
// wpsp_back
// Viewport scaling and a pipelined restoring divider, one quotient bit per
// stage, with rounding and saturation of the screen position.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsp_back
  import wpsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [23:0] vport_i,
  input  wire logic        q_empty_i,
  input  q_item_t          q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [40:0]      out_data_o
);

  localparam int NumW = 58;

  typedef struct packed {
    logic             vis;
    logic             negx;
    logic             negy;
    logic             ovfx;
    logic             ovfy;
    logic [DenW-1:0]  d2;
    logic [RemW-1:0]  rx;
    logic [RemW-1:0]  ry;
    logic [QuotW-1:0] qx;
    logic [QuotW-1:0] qy;
  } div_t;

  logic en;
  logic m_vld_q;
  logic [QuotW+1:0] vld_q;   // scale stage, then QuotW+1 divider slots

  logic signed [NumW-1:0]  nx_q, ny_q;
  logic signed [ClipW-1:0] cw1_q;
  logic                    vis1_q;
  div_t                    st_q [QuotW+1];

  assign en      = !m_vld_q || out_ready_i;
  assign q_pop_o = en && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      m_vld_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[QuotW:0], !q_empty_i};
      m_vld_q <= vld_q[QuotW+1];
    end
  end

  // Scale by width or height times eight.
  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= q_item_i.ax * $signed({1'b0, vport_i[11:0], 3'b000});
      ny_q   <= q_item_i.ay * $signed({1'b0, vport_i[23:12], 3'b000});
      cw1_q  <= q_item_i.cw;
      vis1_q <= q_item_i.vis;
    end
  end

  // Rounded floor division becomes an unsigned magnitude division:
  // a negative dividend n2 gives -floor((|n2| + d2 - 1) / d2).
  always_ff @(posedge clk_i) begin
    logic signed [RemW-1:0] n2x, n2y;
    logic [DenW-1:0]        d2;
    logic [RemW-1:0]        ux, uy;
    if (en) begin
      d2  = {cw1_q[DenW-2:0], 1'b0};
      n2x = (RemW'(nx_q) <<< 1) + RemW'(cw1_q);
      n2y = (RemW'(ny_q) <<< 1) + RemW'(cw1_q);
      ux  = n2x[RemW-1] ? (RemW'(-n2x) + RemW'(d2) - 1'b1) : n2x;
      uy  = n2y[RemW-1] ? (RemW'(-n2y) + RemW'(d2) - 1'b1) : n2y;
      st_q[0].vis  <= vis1_q;
      st_q[0].negx <= n2x[RemW-1];
      st_q[0].negy <= n2y[RemW-1];
      st_q[0].ovfx <= (CmpW'(ux) >= (CmpW'(d2) << QuotW));
      st_q[0].ovfy <= (CmpW'(uy) >= (CmpW'(d2) << QuotW));
      st_q[0].d2   <= d2;
      st_q[0].rx   <= ux;
      st_q[0].ry   <= uy;
      st_q[0].qx   <= '0;
      st_q[0].qy   <= '0;
    end
  end

  for (genvar j = 0; j < QuotW; j++) begin : g_div
    localparam int K = QuotW - 1 - j;
    always_ff @(posedge clk_i) begin
      logic [CmpW-1:0] dk;
      div_t            s;
      if (en) begin
        s  = st_q[j];
        dk = CmpW'(s.d2) << K;
        if (CmpW'(s.rx) >= dk) begin
          s.rx    = s.rx - RemW'(dk);
          s.qx[K] = 1'b1;
        end
        if (CmpW'(s.ry) >= dk) begin
          s.ry    = s.ry - RemW'(dk);
          s.qy[K] = 1'b1;
        end
        st_q[j+1] <= s;
      end
    end
  end

  function automatic logic [QuotW-1:0] sat_q(logic neg, logic ovf, logic [QuotW-1:0] q);
    logic [QuotW-1:0] pos_max;
    logic [QuotW-1:0] neg_min;
    pos_max = {1'b0, {(QuotW-1){1'b1}}};
    neg_min = {1'b1, {(QuotW-1){1'b0}}};
    if (!neg) begin
      sat_q = (ovf || q > pos_max) ? pos_max : q;
    end else begin
      sat_q = (ovf || q > neg_min) ? neg_min : (~q + 1'b1);
    end
  endfunction

  logic [40:0] data_q;
  always_ff @(posedge clk_i) begin
    div_t f;
    if (en) begin
      f = st_q[QuotW];
      if (f.vis) begin
        data_q <= {sat_q(f.negy, f.ovfy, f.qy), sat_q(f.negx, f.ovfx, f.qx), 1'b1};
      end else begin
        data_q <= '0;
      end
    end
  end

  assign out_valid_o = m_vld_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/world_point_screen_projection.sv =====
// ----------------------------------------------------------------------------
// world_point_screen_projection
// Perspective projection of a world point and viewport mapping to 1/16 pixel.
//
//   Channel   Dir  Beat contents
//   s_axis    in   tdata[95:0]: point_x, point_y, point_z
//   m_axis    out  tdata[47:0]: visible, screen_x, screen_y
//   cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i register writes
//
// One point is accepted and one result delivered per cycle when neither side
// stalls. The front registers the relative vector, the products, the clip
// coordinates and the item; then come the queue, the scale stage, divider
// prep, the 20-stage divider and the output register. The queue holds four
// points, so the front keeps taking input while the output is stalled until
// it fills. Reset loads the identity matrix, zero origin, 1920x1080 viewport.
// ----------------------------------------------------------------------------
`default_nettype none

module world_point_screen_projection
  import wpsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // point_x, point_y, point_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // visible, screen_x, screen_y, zero fill
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);

  logic [63:0] row0_q, row1_q, row3_q;
  logic [31:0] org_x_q, org_y_q, org_z_q;
  logic [23:0] vport_q;

  // The clip z row does not take part in the projection, so it is not kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q  <= 64'd256;
      row1_q  <= 64'd16777216;
      row3_q  <= 64'd72057594037927936;
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      vport_q <= 24'd4425600;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROW0:  row0_q  <= cfg_data_i;
        REG_ROW1:  row1_q  <= cfg_data_i;
        REG_ROW3:  row3_q  <= cfg_data_i;
        REG_ORG_X: org_x_q <= cfg_data_i[31:0];
        REG_ORG_Y: org_y_q <= cfg_data_i[31:0];
        REG_ORG_Z: org_z_q <= cfg_data_i[31:0];
        REG_VPORT: vport_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  q_item_t     f_item, b_item;
  front_stat_t f_stat;
  logic        q_full, q_empty, q_pop, q_push;
  logic [40:0] out_data;

  wpsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .row0_i     (row0_q),
    .row1_i     (row1_q),
    .row3_i     (row3_q),
    .org_x_i    (org_x_q),
    .org_y_i    (org_y_q),
    .org_z_i    (org_z_q),
    .q_ready_i  (!q_full),
    .q_item_o   (f_item),
    .stat_o     (f_stat)
  );

  assign s_axis_tready = f_stat.advance;
  assign q_push        = f_stat.out_valid;

  wpsp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (f_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_item_o  (b_item)
  );

  wpsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vport_i     (vport_q),
    .q_empty_i   (q_empty),
    .q_item_i    (b_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = {7'd0, out_data};

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && q_full) |-> !s_axis_tready)
    else $error("front advanced while the queue was full");

  a_front_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_full) |-> s_axis_tready)
    else $error("front stalled although the queue took its item");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[40:1] == '0))
    else $error("hidden point with nonzero screen position");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && !q_empty) |=> $past(!m_axis_tvalid || m_axis_tready))
    else $error("queue popped while output stalled");

endmodule

`default_nettype wire
